// ----- rtl/core/lob_pkg.sv -----
// ---------------------------------------------------------------------------
// lob_pkg
// Shared types and field widths of the limit order book block.
// ---------------------------------------------------------------------------
package lob_pkg;

    localparam int ID_W     = 12;
    localparam int PRICE_W  = 10;
    localparam int QTY_W    = 24;
    localparam int SUM_W    = 36;
    localparam int LVLCNT_W = 13;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_e;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ENTRY,
        ST_LEVEL,
        ST_SCAN,
        ST_SCAN_END,
        ST_CLEAR,
        ST_DONE
    } state_e;

    typedef struct packed {
        op_e                op;
        logic [ID_W-1:0]    ord_ref;
        logic               is_buy;
        logic [PRICE_W-1:0] price_tick;
        logic [QTY_W-1:0]   quantity;
        logic               id_ok;
        logic               price_ok;
    } cmd_t;

    typedef struct packed {
        logic init_busy;
    } status_t;

endpackage

// ----- rtl/core/lob_ram.sv -----
// ---------------------------------------------------------------------------
// lob_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module lob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/lob_front.sv -----
// ---------------------------------------------------------------------------
// lob_front
// Accepts command transactions, checks id and price ranges, and holds them
// in a two-entry queue for the engine.
// ---------------------------------------------------------------------------
module lob_front #(
    parameter int MAX_ORDERS   = 4096,
    parameter int PRICE_LEVELS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [47:0]      s_tdata,
    input  logic [1:0]       s_tuser,
    input  lob_pkg::status_t status,
    input  logic             pop,
    output logic             head_valid,
    output lob_pkg::cmd_t    head
);
    import lob_pkg::*;

    cmd_t        q_reg [2];
    logic        wp_reg;
    logic        wp_next;
    logic        rp_reg;
    logic        rp_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        push;
    cmd_t        in_cmd;
    logic [31:0] id32;
    logic [31:0] pr32;

    assign id32 = 32'(s_tdata[11:0]);
    assign pr32 = 32'(s_tdata[22:13]);

    always_comb
    begin
        in_cmd.op         = op_e'(s_tuser);
        in_cmd.ord_ref    = s_tdata[11:0];
        in_cmd.is_buy     = s_tdata[12];
        in_cmd.price_tick = s_tdata[22:13];
        in_cmd.quantity   = s_tdata[46:23];
        in_cmd.id_ok      = id32 < 32'(MAX_ORDERS);
        in_cmd.price_ok   = pr32 < 32'(PRICE_LEVELS);
    end

    assign s_tready   = (cnt_reg != 2'd2) && !status.init_busy;
    assign push       = s_tvalid && s_tready;
    assign head_valid = cnt_reg != 2'd0;
    assign head       = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_cmd;
        end
    end

endmodule

// ----- rtl/core/lob_engine.sv -----
// ---------------------------------------------------------------------------
// lob_engine
// Carries out queued commands against the order and level memories, keeps
// the best bid and ask, rescans a side and sweeps memories on clear.
// ---------------------------------------------------------------------------
module lob_engine #(
    parameter int MAX_ORDERS   = 4096,
    parameter int PRICE_LEVELS = 1024,
    parameter int QTY_BITS     = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  lob_pkg::cmd_t    head,
    output logic             pop,
    output lob_pkg::status_t status,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,
    output logic [0:0]       m_tuser
);
    import lob_pkg::*;

    localparam int OA       = $clog2(MAX_ORDERS);
    localparam int PA       = $clog2(PRICE_LEVELS);
    localparam int LA       = PA + 1;
    localparam int LV_DEPTH = 2 ** LA;
    localparam int CW       = $clog2(MAX_ORDERS + 1);
    localparam int QW       = (QTY_BITS < QTY_W) ? QTY_BITS : QTY_W;
    localparam int EW       = 1 + PA + QW;
    localparam int LW       = CW + SUM_W;
    localparam int CLR_N    = (MAX_ORDERS > LV_DEPTH) ? MAX_ORDERS : LV_DEPTH;
    localparam int CLR_W    = $clog2(CLR_N);

    state_e             state_reg;
    state_e             state_next;
    cmd_t               cur_reg;
    cmd_t               cur_next;
    logic               lvl_side_reg;
    logic               lvl_side_next;
    logic [PA-1:0]      lvl_price_reg;
    logic [PA-1:0]      lvl_price_next;
    logic               ok_reg;
    logic               ok_next;
    logic [SUM_W-1:0]   lt_reg;
    logic [SUM_W-1:0]   lt_next;
    logic [CW-1:0]      lo_reg;
    logic [CW-1:0]      lo_next;
    logic [PA-1:0]      top_bid_reg;
    logic [PA-1:0]      top_bid_next;
    logic               tbv_reg;
    logic               tbv_next;
    logic [PA-1:0]      top_ask_reg;
    logic [PA-1:0]      top_ask_next;
    logic               tav_reg;
    logic               tav_next;
    logic [CLR_W-1:0]   clr_reg;
    logic [CLR_W-1:0]   clr_next;
    logic [PA-1:0]      scan_ptr_reg;
    logic [PA-1:0]      scan_ptr_next;
    logic [PA-1:0]      scan_at_reg;
    logic [PA-1:0]      scan_at_next;
    logic               scan_pend_reg;
    logic               scan_pend_next;
    logic               scan_side_reg;
    logic               scan_side_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [71:0]        out_data_reg;
    logic [71:0]        out_data_next;
    logic               out_ok_reg;
    logic               out_ok_next;

    logic               vm_we;
    logic [OA-1:0]      vm_waddr;
    logic [0:0]         vm_wdata;
    logic               vm_re;
    logic [OA-1:0]      vm_raddr;
    logic [0:0]         vm_rdata;
    logic               em_we;
    logic [EW-1:0]      em_wdata;
    logic [EW-1:0]      em_rdata;
    logic               lm_we;
    logic [LA-1:0]      lm_waddr;
    logic [LW-1:0]      lm_wdata;
    logic               lm_re;
    logic [LA-1:0]      lm_raddr;
    logic [LW-1:0]      lm_rdata;

    logic [31:0]        head_id32;
    logic [31:0]        cur_id32;
    logic [31:0]        cur_pr32;
    logic [31:0]        cur_q32;
    logic [31:0]        clr32;
    logic [31:0]        bb32;
    logic [31:0]        ba32;
    logic [31:0]        lo32;
    logic [OA-1:0]      head_addr;
    logic [OA-1:0]      cur_addr;
    logic [PA-1:0]      cur_price;
    logic [QW-1:0]      cur_q;
    logic               ent_side;
    logic [PA-1:0]      ent_price;
    logic [QW-1:0]      ent_qty;
    logic [CW-1:0]      lv_cnt;
    logic [SUM_W-1:0]   lv_sum;
    logic               present;
    logic               add_ok;
    logic               ent_acc;
    logic [CW-1:0]      n_cnt;
    logic [SUM_W-1:0]   n_sum;
    logic               need_scan;
    logic               clr_last;
    logic               scan_last;
    logic               out_free;
    logic               scan_hit;

    assign head_id32 = 32'(head.ord_ref);
    assign cur_id32  = 32'(cur_reg.ord_ref);
    assign cur_pr32  = 32'(cur_reg.price_tick);
    assign cur_q32   = 32'(cur_reg.quantity);
    assign clr32     = 32'(clr_reg);
    assign bb32      = 32'(top_bid_reg);
    assign ba32      = 32'(top_ask_reg);
    assign lo32      = 32'(lo_reg);
    assign head_addr = head_id32[OA-1:0];
    assign cur_addr  = cur_id32[OA-1:0];
    assign cur_price = cur_pr32[PA-1:0];
    assign cur_q     = cur_q32[QW-1:0];
    assign ent_side  = em_rdata[EW-1];
    assign ent_price = em_rdata[QW +: PA];
    assign ent_qty   = em_rdata[QW-1:0];
    assign lv_cnt    = lm_rdata[LW-1 -: CW];
    assign lv_sum    = lm_rdata[SUM_W-1:0];

    assign present   = cur_reg.id_ok && vm_rdata[0];
    assign add_ok    = cur_reg.id_ok && !vm_rdata[0] && cur_reg.price_ok;
    assign ent_acc   = (cur_reg.op == OP_ADD) ? add_ok :
                       ((cur_reg.op == OP_REMOVE || cur_reg.op == OP_UPDATE) && present);
    assign clr_last  = clr_reg == CLR_W'(CLR_N - 1);
    assign scan_last = scan_ptr_reg == PA'(PRICE_LEVELS - 1);
    assign out_free  = !m_valid_reg || m_tready;
    assign scan_hit  = scan_pend_reg && (lv_cnt != '0);

    always_comb
    begin
        case (cur_reg.op)
            OP_ADD:
            begin
                n_cnt = lv_cnt + CW'(1);
                n_sum = lv_sum + SUM_W'(cur_q);
            end
            OP_REMOVE:
            begin
                n_cnt = (lv_cnt != '0) ? (lv_cnt - CW'(1)) : lv_cnt;
                n_sum = lv_sum - SUM_W'(ent_qty);
            end
            OP_UPDATE:
            begin
                n_cnt = lv_cnt;
                n_sum = lv_sum - SUM_W'(ent_qty) + SUM_W'(cur_q);
            end
            default:
            begin
                n_cnt = lv_cnt;
                n_sum = lv_sum;
            end
        endcase
    end

    assign need_scan = (cur_reg.op == OP_REMOVE) && (n_cnt == '0) &&
                       (lvl_side_reg ? (tbv_reg && lvl_price_reg == top_bid_reg)
                                     : (tav_reg && lvl_price_reg == top_ask_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:     state_next = clr_last ? ST_IDLE : ST_INIT;
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = (head.op == OP_CLEAR) ? ST_CLEAR : ST_ENTRY;
                end
            end
            ST_ENTRY:    state_next = ent_acc ? ST_LEVEL : ST_DONE;
            ST_LEVEL:    state_next = need_scan ? ST_SCAN : ST_DONE;
            ST_SCAN:     state_next = scan_last ? ST_SCAN_END : ST_SCAN;
            ST_SCAN_END: state_next = ST_DONE;
            ST_CLEAR:    state_next = clr_last ? ST_DONE : ST_CLEAR;
            ST_DONE:     state_next = out_free ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    assign pop              = (state_reg == ST_IDLE) && head_valid;
    assign status.init_busy = state_reg == ST_INIT;

    always_comb
    begin
        cur_next       = cur_reg;
        lvl_side_next  = lvl_side_reg;
        lvl_price_next = lvl_price_reg;
        ok_next        = ok_reg;
        lt_next        = lt_reg;
        lo_next        = lo_reg;
        top_bid_next   = top_bid_reg;
        tbv_next       = tbv_reg;
        top_ask_next   = top_ask_reg;
        tav_next       = tav_reg;
        clr_next       = clr_reg;
        scan_ptr_next  = scan_ptr_reg;
        scan_at_next   = scan_at_reg;
        scan_pend_next = scan_pend_reg;
        scan_side_next = scan_side_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_ok_next    = out_ok_reg;
        vm_we          = 1'b0;
        vm_waddr       = cur_addr;
        vm_wdata       = 1'b0;
        vm_re          = 1'b0;
        vm_raddr       = head_addr;
        em_we          = 1'b0;
        em_wdata       = {cur_reg.is_buy, cur_price, cur_q};
        lm_we          = 1'b0;
        lm_waddr       = {lvl_side_reg, lvl_price_reg};
        lm_wdata       = {n_cnt, n_sum};
        lm_re          = 1'b0;
        lm_raddr       = {scan_side_reg, scan_ptr_reg};
        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                vm_waddr = clr_reg[OA-1:0];
                vm_we    = clr32 < 32'(MAX_ORDERS);
                lm_waddr = clr_reg[LA-1:0];
                lm_wdata = '0;
                lm_we    = clr32 < 32'(LV_DEPTH);
                clr_next = clr_last ? '0 : (clr_reg + CLR_W'(1));
                if (clr_last)
                begin
                    top_bid_next = '0;
                    tbv_next     = 1'b0;
                    top_ask_next = '0;
                    tav_next     = 1'b0;
                    ok_next      = 1'b1;
                    lt_next      = '0;
                    lo_next      = '0;
                end
            end
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    cur_next = head;
                    vm_re    = head.op != OP_CLEAR;
                    clr_next = '0;
                end
            end
            ST_ENTRY:
            begin
                lvl_side_next  = (cur_reg.op == OP_ADD) ? cur_reg.is_buy : ent_side;
                lvl_price_next = (cur_reg.op == OP_ADD) ? cur_price : ent_price;
                lm_raddr       = {lvl_side_next, lvl_price_next};
                lm_re          = ent_acc;
                ok_next        = ent_acc;
                lt_next        = '0;
                lo_next        = '0;
            end
            ST_LEVEL:
            begin
                lm_we   = 1'b1;
                lt_next = n_sum;
                lo_next = n_cnt;
                case (cur_reg.op)
                    OP_ADD:
                    begin
                        vm_we    = 1'b1;
                        vm_wdata = 1'b1;
                        em_we    = 1'b1;
                        if (cur_reg.is_buy)
                        begin
                            if (!tbv_reg || cur_price > top_bid_reg)
                            begin
                                top_bid_next = cur_price;
                                tbv_next     = 1'b1;
                            end
                        end
                        else
                        begin
                            if (!tav_reg || cur_price < top_ask_reg)
                            begin
                                top_ask_next = cur_price;
                                tav_next     = 1'b1;
                            end
                        end
                    end
                    OP_REMOVE:
                    begin
                        vm_we = 1'b1;
                    end
                    OP_UPDATE:
                    begin
                        em_we    = 1'b1;
                        em_wdata = {ent_side, ent_price, cur_q};
                    end
                    default:
                    begin
                        em_we = 1'b0;
                    end
                endcase
                if (need_scan)
                begin
                    scan_ptr_next  = '0;
                    scan_pend_next = 1'b0;
                    scan_side_next = lvl_side_reg;
                    if (lvl_side_reg)
                    begin
                        top_bid_next = '0;
                        tbv_next     = 1'b0;
                    end
                    else
                    begin
                        top_ask_next = '0;
                        tav_next     = 1'b0;
                    end
                end
            end
            ST_SCAN, ST_SCAN_END:
            begin
                lm_re          = state_reg == ST_SCAN;
                scan_pend_next = state_reg == ST_SCAN;
                scan_at_next   = scan_ptr_reg;
                scan_ptr_next  = scan_ptr_reg + PA'(1);
                if (scan_hit)
                begin
                    if (scan_side_reg)
                    begin
                        top_bid_next = scan_at_reg;
                        tbv_next     = 1'b1;
                    end
                    else if (!tav_reg)
                    begin
                        top_ask_next = scan_at_reg;
                        tav_next     = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    out_ok_next   = ok_reg;
                    out_data_next = {
                        1'b0,
                        lo32[LVLCNT_W-1:0],
                        lt_reg,
                        tav_reg,
                        tav_reg ? ba32[PRICE_W-1:0] : PRICE_W'(0),
                        tbv_reg,
                        tbv_reg ? bb32[PRICE_W-1:0] : PRICE_W'(0)
                    };
                end
            end
            default:
            begin
                m_valid_next = m_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_reg       <= '0;
            top_bid_reg   <= '0;
            tbv_reg       <= 1'b0;
            top_ask_reg   <= '0;
            tav_reg       <= 1'b0;
            scan_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            top_bid_reg   <= top_bid_next;
            tbv_reg       <= tbv_next;
            top_ask_reg   <= top_ask_next;
            tav_reg       <= tav_next;
            scan_pend_reg <= scan_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        lvl_side_reg  <= lvl_side_next;
        lvl_price_reg <= lvl_price_next;
        ok_reg        <= ok_next;
        lt_reg        <= lt_next;
        lo_reg        <= lo_next;
        scan_ptr_reg  <= scan_ptr_next;
        scan_at_reg   <= scan_at_next;
        scan_side_reg <= scan_side_next;
        out_data_reg  <= out_data_next;
        out_ok_reg    <= out_ok_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

    lob_ram #(.WIDTH(1), .DEPTH(MAX_ORDERS)) u_valid_ram (
        .clk   (clk),
        .we    (vm_we),
        .waddr (vm_waddr),
        .wdata (vm_wdata),
        .re    (vm_re),
        .raddr (vm_raddr),
        .rdata (vm_rdata)
    );

    lob_ram #(.WIDTH(EW), .DEPTH(MAX_ORDERS)) u_entry_ram (
        .clk   (clk),
        .we    (em_we),
        .waddr (vm_waddr),
        .wdata (em_wdata),
        .re    (vm_re),
        .raddr (vm_raddr),
        .rdata (em_rdata)
    );

    lob_ram #(.WIDTH(LW), .DEPTH(LV_DEPTH)) u_level_ram (
        .clk   (clk),
        .we    (lm_we),
        .waddr (lm_waddr),
        .wdata (lm_wdata),
        .re    (lm_re),
        .raddr (lm_raddr),
        .rdata (lm_rdata)
    );

endmodule

// ----- rtl/core/limit_order_book_top.sv -----
// ---------------------------------------------------------------------------
// limit_order_book_top
// Order book keeper with per-level counts and totals and best bid and ask.
// ---------------------------------------------------------------------------
// An add, remove or update goes through the engine as an order table
// read, a level read, the level and table write, and the result transaction.
// A remove that empties the best level of its side then walks that side
// through the single read port of the level memory to find the new best.
// A clear, and the sweep after reset, write every address of the order and
// level memories; no command transaction is accepted during the sweep after
// reset. A two-entry queue lets the input side accept commands while the
// engine works.
module limit_order_book_top #(
    parameter int MAX_ORDERS   = 4096,
    parameter int PRICE_LEVELS = 1024,
    parameter int QTY_BITS     = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // ord_ref[11:0], is_buy[12], price_tick[22:13], quantity[46:23].
    input  logic [47:0] s_tdata,
    // cmd[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // best_bid[9:0], has_bid[10], best_ask[20:11], has_ask[21],
    // level_total[57:22], level_orders[70:58].
    output logic [71:0] m_tdata,
    // ok[0].
    output logic [0:0]  m_tuser
);
    import lob_pkg::*;

    status_t status;
    logic    pop;
    logic    head_valid;
    cmd_t    head;

    lob_front #(
        .MAX_ORDERS   (MAX_ORDERS),
        .PRICE_LEVELS (PRICE_LEVELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .status     (status),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    lob_engine #(
        .MAX_ORDERS   (MAX_ORDERS),
        .PRICE_LEVELS (PRICE_LEVELS),
        .QTY_BITS     (QTY_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        status.init_busy |-> !s_tready)
        else $error("command accepted during reset sweep");

    a_no_bid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[10]) |-> (m_tdata[9:0] == 10'd0))
        else $error("best bid nonzero without a bid");

    a_no_ask_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[21]) |-> (m_tdata[20:11] == 10'd0))
        else $error("best ask nonzero without an ask");

    a_reject_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[70:22] == 49'd0))
        else $error("rejected command reports level data");

endmodule

// ----- dv/limit_order_book_top_test.sv -----
// ---------------------------------------------------------------------------
// limit_order_book_top_test
// Self-checking testbench for the order book keeper.
// ---------------------------------------------------------------------------
// Commands go in on the input stream with random gaps, and results are taken
// with random stalls. A scoreboard keeps its own copy of the order table,
// the per-level counts and totals and the best prices. It predicts one
// result for each accepted command and compares every result field by field.
// ---------------------------------------------------------------------------
module limit_order_book_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lob_pkg::*;

    typedef struct {
        logic               ok;
        logic [PRICE_W-1:0] best_bid;
        logic               has_bid;
        logic [PRICE_W-1:0] best_ask;
        logic               has_ask;
        logic [SUM_W-1:0]   level_total;
        logic [LVLCNT_W-1:0] level_orders;
    } book_result_t;

    class book_scoreboard;
        bit                  live[4096];
        bit                  buy_side[4096];
        logic [PRICE_W-1:0]  tick_of[4096];
        logic [QTY_W-1:0]    qty_of[4096];
        logic [LVLCNT_W-1:0] bid_cnt[1024];
        logic [LVLCNT_W-1:0] ask_cnt[1024];
        logic [SUM_W-1:0]    bid_sum[1024];
        logic [SUM_W-1:0]    ask_sum[1024];
        logic [PRICE_W-1:0]  top_bid;
        logic [PRICE_W-1:0]  top_ask;
        bit                  bid_ok;
        bit                  ask_ok;
        book_result_t        pending[$];
        int                  errors;
        int                  checked;

        function void wipe();
            for (int i = 0; i < 4096; i++)
                live[i] = 0;
            for (int p = 0; p < 1024; p++)
            begin
                bid_cnt[p] = 0;
                ask_cnt[p] = 0;
                bid_sum[p] = 0;
                ask_sum[p] = 0;
            end
            top_bid = 0;
            top_ask = 0;
            bid_ok = 0;
            ask_ok = 0;
        endfunction

        function void note_command(op_e op, logic [ID_W-1:0] id, logic buy,
                                   logic [PRICE_W-1:0] px, logic [QTY_W-1:0] q);
            book_result_t r;
            logic [PRICE_W-1:0] p;
            r.ok = 0;
            r.level_total = 0;
            r.level_orders = 0;
            case (op)
                OP_ADD:
                begin
                    if (!live[id])
                    begin
                        r.ok = 1;
                        live[id] = 1;
                        buy_side[id] = buy;
                        tick_of[id] = px;
                        qty_of[id] = q;
                        if (buy)
                        begin
                            bid_cnt[px]++;
                            bid_sum[px] += q;
                            r.level_total = bid_sum[px];
                            r.level_orders = bid_cnt[px];
                            if (!bid_ok || px > top_bid)
                            begin
                                top_bid = px;
                                bid_ok = 1;
                            end
                        end
                        else
                        begin
                            ask_cnt[px]++;
                            ask_sum[px] += q;
                            r.level_total = ask_sum[px];
                            r.level_orders = ask_cnt[px];
                            if (!ask_ok || px < top_ask)
                            begin
                                top_ask = px;
                                ask_ok = 1;
                            end
                        end
                    end
                end
                OP_REMOVE:
                begin
                    if (live[id])
                    begin
                        p = tick_of[id];
                        r.ok = 1;
                        live[id] = 0;
                        if (buy_side[id])
                        begin
                            if (bid_cnt[p] != 0)
                                bid_cnt[p]--;
                            bid_sum[p] -= qty_of[id];
                            r.level_total = bid_sum[p];
                            r.level_orders = bid_cnt[p];
                            if (bid_cnt[p] == 0 && bid_ok && p == top_bid)
                            begin
                                top_bid = 0;
                                bid_ok = 0;
                                for (int k = 0; k < 1024; k++)
                                    if (bid_cnt[k] != 0)
                                    begin
                                        top_bid = k;
                                        bid_ok = 1;
                                    end
                            end
                        end
                        else
                        begin
                            if (ask_cnt[p] != 0)
                                ask_cnt[p]--;
                            ask_sum[p] -= qty_of[id];
                            r.level_total = ask_sum[p];
                            r.level_orders = ask_cnt[p];
                            if (ask_cnt[p] == 0 && ask_ok && p == top_ask)
                            begin
                                top_ask = 0;
                                ask_ok = 0;
                                for (int k = 1023; k >= 0; k--)
                                    if (ask_cnt[k] != 0)
                                    begin
                                        top_ask = k;
                                        ask_ok = 1;
                                    end
                            end
                        end
                    end
                end
                OP_UPDATE:
                begin
                    if (live[id])
                    begin
                        p = tick_of[id];
                        r.ok = 1;
                        if (buy_side[id])
                        begin
                            bid_sum[p] = bid_sum[p] - qty_of[id] + q;
                            r.level_total = bid_sum[p];
                            r.level_orders = bid_cnt[p];
                        end
                        else
                        begin
                            ask_sum[p] = ask_sum[p] - qty_of[id] + q;
                            r.level_total = ask_sum[p];
                            r.level_orders = ask_cnt[p];
                        end
                        qty_of[id] = q;
                    end
                end
                default:
                begin
                    wipe();
                    r.ok = 1;
                end
            endcase
            r.best_bid = bid_ok ? top_bid : '0;
            r.has_bid = bid_ok;
            r.best_ask = ask_ok ? top_ask : '0;
            r.has_ask = ask_ok;
            pending = {pending, r};
        endfunction

        function void check_result(book_result_t got);
            book_result_t e;
            if (pending.size() == 0)
            begin
                $error("result transaction with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.ok !== e.ok)
            begin
                $error("ok: expected %0d, got %0d", e.ok, got.ok);
                errors++;
            end
            if (got.best_bid !== e.best_bid)
            begin
                $error("best_bid: expected %0d, got %0d", e.best_bid, got.best_bid);
                errors++;
            end
            if (got.has_bid !== e.has_bid)
            begin
                $error("has_bid: expected %0d, got %0d", e.has_bid, got.has_bid);
                errors++;
            end
            if (got.best_ask !== e.best_ask)
            begin
                $error("best_ask: expected %0d, got %0d", e.best_ask, got.best_ask);
                errors++;
            end
            if (got.has_ask !== e.has_ask)
            begin
                $error("has_ask: expected %0d, got %0d", e.has_ask, got.has_ask);
                errors++;
            end
            if (got.level_total !== e.level_total)
            begin
                $error("level_total: expected %0d, got %0d", e.level_total,
                       got.level_total);
                errors++;
            end
            if (got.level_orders !== e.level_orders)
            begin
                $error("level_orders: expected %0d, got %0d", e.level_orders,
                       got.level_orders);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;

    book_scoreboard book;
    bit             hold_results;
    int             adds_sent;
    int             removes_sent;
    int             updates_sent;
    int             clears_sent;

    limit_order_book_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Returns at the falling edge after the accepting edge with s_tvalid still
    // high; the caller either sends the next command at once or drops it.
    task automatic send_command(op_e op, logic [ID_W-1:0] id, logic buy,
                                logic [PRICE_W-1:0] px, logic [QTY_W-1:0] q,
                                bit with_gap);
        int gap;
        gap = with_gap ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, q, px, buy, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        book.note_command(op, id, buy, px, q);
        case (op)
            OP_ADD:    adds_sent++;
            OP_REMOVE: removes_sent++;
            OP_UPDATE: updates_sent++;
            default:   clears_sent++;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (book.pending.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_command(int id_span, int px_lo, int px_hi);
        int r;
        logic [ID_W-1:0] id;
        r = $urandom_range(0, 999);
        id = $urandom_range(0, id_span);
        if (r < 2)
            send_command(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, 1);
        else if (r < 450)
            send_command(OP_ADD, id, $urandom, $urandom_range(px_lo, px_hi),
                         $urandom, 1);
        else if (r < 750)
            send_command(OP_REMOVE, id, $urandom, $urandom, $urandom, 1);
        else
            send_command(OP_UPDATE, id, $urandom, $urandom,
                         ($urandom_range(0, 9) == 0) ? '0 : $urandom, 1);
    endtask

    always @(posedge clk)
    begin
        book_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.best_bid     = m_tdata[9:0];
            got.has_bid      = m_tdata[10];
            got.best_ask     = m_tdata[20:11];
            got.has_ask      = m_tdata[21];
            got.level_total  = m_tdata[57:22];
            got.level_orders = m_tdata[70:58];
            got.ok           = m_tuser[0];
            book.check_result(got);
        end
    end

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(0, 99) < 70);
        end
    end

    initial
    begin
        #200ms;
        $display("limit_order_book_top verification failed");
        $finish;
    end

    initial
    begin
        book = new();
        book.wipe();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_ADD;
        hold_results = 0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, duplicates, unknown ids, best-level rescans.
        send_command(OP_REMOVE, 12'd5, 1'b0, 10'd0, 24'd0, 0);
        send_command(OP_UPDATE, 12'hFFF, 1'b1, 10'h3FF, 24'hFFFFFF, 0);
        send_command(OP_ADD, 12'd0, 1'b1, 10'd0, 24'hFFFFFF, 0);
        send_command(OP_ADD, 12'hFFF, 1'b1, 10'h3FF, 24'hFFFFFF, 0);
        send_command(OP_ADD, 12'hFFF, 1'b0, 10'd5, 24'd1, 0);
        send_command(OP_ADD, 12'd1, 1'b0, 10'h3FF, 24'd0, 0);
        send_command(OP_ADD, 12'd2, 1'b0, 10'd0, 24'hAAAAAA, 0);
        send_command(OP_ADD, 12'd3, 1'b0, 10'd0, 24'h555555, 0);
        send_command(OP_ADD, 12'd4, 1'b1, 10'h3FF, 24'd7, 0);
        send_command(OP_UPDATE, 12'd2, 1'b0, 10'd0, 24'd0, 0);
        send_command(OP_UPDATE, 12'd4, 1'b0, 10'd0, 24'hFFFFFF, 0);
        send_command(OP_REMOVE, 12'hFFF, 1'b0, 10'd0, 24'd0, 0);
        send_command(OP_REMOVE, 12'd4, 1'b0, 10'd0, 24'd0, 0);
        send_command(OP_REMOVE, 12'd2, 1'b0, 10'd0, 24'd0, 0);
        send_command(OP_REMOVE, 12'd3, 1'b0, 10'd0, 24'd0, 0);
        send_command(OP_REMOVE, 12'd3, 1'b0, 10'd0, 24'd0, 0);
        send_command(OP_REMOVE, 12'd0, 1'b0, 10'd0, 24'd0, 0);
        send_command(OP_ADD, 12'd9, 1'b1, 10'd100, 24'd3, 0);
        send_command(OP_CLEAR, 12'hABC, 1'b1, 10'h2AA, 24'h123456, 0);
        send_command(OP_REMOVE, 12'd9, 1'b0, 10'd0, 24'd0, 0);
        send_command(OP_ADD, 12'd9, 1'b0, 10'd512, 24'd1, 0);

        // The sender waits for the book to answer everything.
        wait_drained();

        // Results held back while commands keep coming.
        fork
            begin
                hold_results = 1;
                repeat (300)
                    @(negedge clk);
                hold_results = 0;
            end
            begin
                repeat (12)
                    random_command(31, 0, 15);
                s_tvalid <= 1'b0;
            end
        join
        @(negedge clk);

        // Random: mostly a small id and price space so that levels fill.
        for (int n = 0; n < 880; n++)
        begin
            if (n < 700)
                random_command(63, 0, 31);
            else
                random_command(4095, 0, 1023);
        end

        wait_drained();
        repeat (2000)
            @(negedge clk);

        $display("Covered %0d adds, %0d removes, %0d updates, %0d clears;",
                 adds_sent, removes_sent, updates_sent, clears_sent);
        $display("%0d results checked.", book.checked);
        if (book.errors == 0 && book.pending.size() == 0)
            $display("limit_order_book_top verification clean");
        else
            $display("limit_order_book_top verification failed");
        $finish;
    end
endmodule
